### hdl/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg: shared types and constants of the bit-packed unpacker
// Request and result payload structs, window geometry and register reset.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int FULL_WIDTH   = 32;   // field width that selects raw word pass-through
  localparam int NUM_LANES    = 8;    // value slots in one result
  localparam int WINDOW_BITS  = 256;  // bits in one packed window
  localparam int BYTE_BITS    = 8;
  localparam int CHUNK_BITS   = 40;   // byte-aligned slice that covers one field plus offset
  localparam int POS_BITS     = 8;    // bit position of a field inside the window
  localparam int WIDTH_BITS   = 6;    // width of the field width register
  localparam int DEFAULT_NUM_VALUES = 8;

  localparam logic [WIDTH_BITS-1:0] BIT_WIDTH_RESET = 6'd8;

  typedef struct packed {
    logic [63:0] packed_word_3;
    logic [63:0] packed_word_2;
    logic [63:0] packed_word_1;
    logic [63:0] packed_word_0;
    logic [2:0]  bit_offset;
  } in_req_t;

  typedef struct packed {
    logic [31:0] value_7;
    logic [31:0] value_6;
    logic [31:0] value_5;
    logic [31:0] value_4;
    logic [31:0] value_3;
    logic [31:0] value_2;
    logic [31:0] value_1;
    logic [31:0] value_0;
  } out_res_t;

endpackage

### hdl/bit_packed_unpacker.sv
// ----------------------------------------------------------------------------
// bit_packed_unpacker: fixed-width unpacking of a 256-bit packed window
// Three-stage pipeline: field positions, byte-aligned slice, bit shift + mask.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_ready / in_data carry one request: four 64-bit packed words
//   (window bits 0-255, little-endian) and a start bit offset of 0 to 7.
//   out_valid / out_ready / out_data return eight 32-bit unsigned fields; field
//   i starts at offset + width * i. A width of 32 or more passes the eight raw
//   words through and ignores the offset; a width of 0 gives zeros.
//   cfg_wr_en / cfg_wr_data write the 6-bit field width; write
//   it only while no request is in flight.
//   Pipeline: three register stages (position compute, 32-way byte select per
//   lane, 8-way bit shift per lane); out_valid follows the third stage's valid
//   bit. Throughput: one request per cycle while out_ready stays high; each
//   stage takes a new request whenever the stage after it is empty or moving.
//   Reset (rst, synchronous) empties the pipeline and sets the width to 8.
//   When the receiver holds out_ready low, the result stays on out_data and
//   the stages behind it fill; in_ready drops once all three stages hold a
//   request, and no request is lost or repeated.
// ----------------------------------------------------------------------------
module bit_packed_unpacker #(
  parameter int NUM_VALUES = bpu_pkg::DEFAULT_NUM_VALUES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [bpu_pkg::WIDTH_BITS-1:0]   cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bpu_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bpu_pkg::out_res_t                out_data
);
  import bpu_pkg::*;

  localparam int PAD_BITS = WINDOW_BITS + CHUNK_BITS;

  // Configuration register
  logic [WIDTH_BITS-1:0] field_width;

  // Pipeline valid bits and stage enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  // Stage 1: window, per-lane start position, field mask
  logic [WINDOW_BITS-1:0] s1_win;
  logic [POS_BITS-1:0]    s1_pos [NUM_VALUES];
  logic [31:0]            s1_mask;
  logic [WIDTH_BITS-1:0]  s1_width;

  // Stage 2: byte-aligned slice and residual bit shift per lane
  logic [CHUNK_BITS-1:0]  s2_chunk [NUM_VALUES];
  logic [2:0]             s2_fine  [NUM_VALUES];
  logic [31:0]            s2_mask;

  // Stage 3: finished values
  logic [31:0]            s3_val [NUM_VALUES];

  // Combinational next values
  logic [WIDTH_BITS-1:0]  width_eff;
  logic [2:0]             offset_eff;
  logic [31:0]            mask_next;
  logic [POS_BITS-1:0]    pos_next   [NUM_VALUES];
  logic [PAD_BITS-1:0]    win_ext;
  logic [CHUNK_BITS-1:0]  chunk_next [NUM_VALUES];
  logic [CHUNK_BITS-1:0]  shifted    [NUM_VALUES];
  logic [31:0]            val_next   [NUM_VALUES];
  logic [31:0]            lane_out   [NUM_LANES];

  // Hold the field width
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= BIT_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      field_width <= cfg_wr_data;
    end
  end

  // Advance a stage when the one after it is empty or moving
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Saturate the width; full width drops the offset
  always_comb begin
    if (field_width >= WIDTH_BITS'(FULL_WIDTH)) begin
      width_eff  = WIDTH_BITS'(FULL_WIDTH);
      offset_eff = 3'd0;
      mask_next  = '1;
    end else begin
      width_eff  = field_width;
      offset_eff = in_data.bit_offset;
      mask_next  = (32'd1 << field_width[4:0]) - 32'd1;
    end
    for (int i = 0; i < NUM_VALUES; i++) begin
      pos_next[i] = POS_BITS'(offset_eff) + POS_BITS'(width_eff) * POS_BITS'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_win   <= {in_data.packed_word_3, in_data.packed_word_2,
                   in_data.packed_word_1, in_data.packed_word_0};
      s1_pos   <= pos_next;
      s1_mask  <= mask_next;
      s1_width <= width_eff;
    end
  end

  // Select the byte-aligned slice; bits past the window read as zero
  assign win_ext = {{CHUNK_BITS{1'b0}}, s1_win};

  always_comb begin
    for (int i = 0; i < NUM_VALUES; i++) begin
      chunk_next[i] = win_ext[BYTE_BITS * int'(s1_pos[i][POS_BITS-1:3]) +: CHUNK_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_chunk <= chunk_next;
      for (int i = 0; i < NUM_VALUES; i++) begin
        s2_fine[i] <= s1_pos[i][2:0];
      end
      s2_mask <= s1_mask;
    end
  end

  // Shift out the residual bits and mask to the width
  always_comb begin
    for (int i = 0; i < NUM_VALUES; i++) begin
      shifted[i]  = s2_chunk[i] >> s2_fine[i];
      val_next[i] = shifted[i][31:0] & s2_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_val <= val_next;
    end
  end

  // Drive unused value slots to zero
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_out[i] = '0;
    end
    for (int i = 0; i < NUM_VALUES; i++) begin
      lane_out[i] = s3_val[i];
    end
  end

  assign out_valid        = v3;
  assign out_data.value_0 = lane_out[0];
  assign out_data.value_1 = lane_out[1];
  assign out_data.value_2 = lane_out[2];
  assign out_data.value_3 = lane_out[3];
  assign out_data.value_4 = lane_out[4];
  assign out_data.value_5 = lane_out[5];
  assign out_data.value_6 = lane_out[6];
  assign out_data.value_7 = lane_out[7];

`ifndef SYNTH
  // Stalled stage 1 keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(s1_win) && $stable(s1_mask))
    else $error("stage 1 request changed while stalled");

  // Stalled stage 2 keeps its request
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(s2_chunk[0]) && $stable(s2_mask))
    else $error("stage 2 request changed while stalled");

  // Saturated width never exceeds a full word
  a_width_sat: assert property (@(posedge clk) disable iff (rst)
    v1 |-> s1_width <= WIDTH_BITS'(FULL_WIDTH))
    else $error("effective width above full word");

  // A full pipeline with a stalled receiver refuses new requests
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && !out_ready |-> !in_ready)
    else $error("request accepted into a full pipeline");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");
`endif

endmodule
